>>> sv/dpc_pkg.sv
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types and constants for the debounced press counter.
// ----------------------------------------------------------------------------
package dpc_pkg;

   localparam int DB_TICKS_W  = 8;
   localparam int LP_TICKS_W  = 16;
   localparam int COUNT_W     = 30;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int BCD_W       = 4;

   localparam logic [DB_TICKS_W-1:0] DB_TICKS_RESET = 8'd2;
   localparam logic [LP_TICKS_W-1:0] LP_TICKS_RESET = 16'd200;
   localparam logic [BCD_W-1:0]      BCD_NINE       = 4'd9;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE_TICKS   = 1'd0,
      CSR_LONG_PRESS_TICKS = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE         = 2'd0,
      PH_DEBOUNCE     = 2'd1,
      PH_HOLD         = 2'd2,
      PH_WAIT_RELEASE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_SHORT = 2'd1,
      EV_LONG  = 2'd2
   } event_type;

   // counter commands from the controller, already qualified by the tick
   typedef struct packed {
      logic inc;
      logic clr;
   } count_cmd_type;

endpackage

>>> sv/dpc_bcd_cell.sv
// ----------------------------------------------------------------------------
// dpc_bcd_cell
// One decimal digit of the press counter; passes its carry to the next digit.
// ----------------------------------------------------------------------------
module dpc_bcd_cell
   import dpc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             clr,
   input  logic             carry_in,
   output logic             carry_out,
   output logic [BCD_W-1:0] digit
);

   logic [BCD_W-1:0] digit_ff;
   logic [BCD_W-1:0] digit_in;

   always_comb begin
      carry_out = 1'b0;
      digit_in  = digit_ff;
      if (clr) begin
         digit_in = '0;
      end else if (carry_in) begin
         if (digit_ff >= BCD_NINE) begin
            digit_in  = '0;
            carry_out = 1'b1;
         end else begin
            digit_in = digit_ff + BCD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
      end else begin
         digit_ff <= digit_in;
      end
   end

   assign digit = digit_ff;

endmodule

>>> sv/dpc_ctrl.sv
// ----------------------------------------------------------------------------
// dpc_ctrl
// Press phase machine and saturating tick timer.
// ----------------------------------------------------------------------------
module dpc_ctrl
   import dpc_pkg::*;
#(
   parameter int TIMER_BITS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  pressed,
   input  logic [DB_TICKS_W-1:0] debounce_ticks,
   input  logic [LP_TICKS_W-1:0] long_press_ticks,
   output count_cmd_type         cmd,
   output event_type             event_code
);

   localparam int CMP_W = (TIMER_BITS > LP_TICKS_W) ? TIMER_BITS : LP_TICKS_W;

   phase_type               phase_ff, phase_in;
   logic [TIMER_BITS-1:0]   timer_ff, timer_in;
   event_type               event_ff, event_in;
   logic [TIMER_BITS-1:0]   timer_inc;
   logic [CMP_W-1:0]        timer_ext;
   logic                    db_done;
   logic                    lp_done;

   assign timer_inc = (timer_ff == {TIMER_BITS{1'b1}}) ? timer_ff
                                                       : timer_ff + TIMER_BITS'(1);
   assign timer_ext = CMP_W'(timer_inc);
   assign db_done   = timer_ext >= CMP_W'(debounce_ticks);
   assign lp_done   = timer_ext >= CMP_W'(long_press_ticks);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         timer_ff <= '0;
         event_ff <= EV_NONE;
      end else if (step) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         event_ff <= event_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      event_in = EV_NONE;
      cmd      = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (pressed) begin
               phase_in = PH_DEBOUNCE;
               timer_in = '0;
            end
         end
         PH_DEBOUNCE: begin
            timer_in = timer_inc;
            if (db_done) begin
               if (pressed) begin
                  phase_in = PH_HOLD;
                  timer_in = '0;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_HOLD: begin
            timer_in = timer_inc;
            if (lp_done) begin
               cmd.clr  = step;
               event_in = EV_LONG;
               phase_in = pressed ? PH_WAIT_RELEASE : PH_IDLE;
            end else if (!pressed) begin
               cmd.inc  = step;
               event_in = EV_SHORT;
               phase_in = PH_IDLE;
            end
         end
         PH_WAIT_RELEASE: begin
            if (!pressed) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   assign event_code = event_ff;

endmodule

>>> sv/debounced_press_counter_long_reset.sv
// ----------------------------------------------------------------------------
// debounced_press_counter_long_reset
// Debounced button press counter with decimal digits and long-press clear.
// ----------------------------------------------------------------------------
// latency: the result word for a tick is valid the cycle after the tick is taken
// throughput: one tick per cycle; the digit carry ripples through the cell row
// within that cycle, and a new tick is taken in the same cycle a waiting word leaves
// reset: synchronous; counter, digits and timer clear, phase goes idle,
// debounce_ticks returns to 2 and long_press_ticks to 200
module debounced_press_counter_long_reset
   import dpc_pkg::*;
#(
   parameter int DIGITS     = 9,
   parameter int TIMER_BITS = 16
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_button_level,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [COUNT_W-1:0]       rsp_count_value,
   output logic [BCD_W*DIGITS-1:0]  rsp_count_digits,
   output logic [1:0]               rsp_event_code,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   logic [DB_TICKS_W-1:0] db_ticks_ff;
   logic [LP_TICKS_W-1:0] lp_ticks_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  req_accept;
   count_cmd_type         cmd;
   event_type             event_code;
   logic [DIGITS:0]       carry;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         db_ticks_ff <= DB_TICKS_RESET;
         lp_ticks_ff <= LP_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_DEBOUNCE_TICKS) begin
            db_ticks_ff <= csr_data[DB_TICKS_W-1:0];
         end
         if (csr_index == CSR_LONG_PRESS_TICKS) begin
            lp_ticks_ff <= csr_data[LP_TICKS_W-1:0];
         end
      end
   end

   // output word register; state only moves on an accepted tick
   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign req_accept   = req_valid && !req_stall;
   assign rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   dpc_ctrl #(
      .TIMER_BITS (TIMER_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .step             (req_accept),
      .pressed          (!req_button_level),
      .debounce_ticks   (db_ticks_ff),
      .long_press_ticks (lp_ticks_ff),
      .cmd              (cmd),
      .event_code       (event_code)
   );

   // decimal digit row, least significant cell first
   assign carry[0] = cmd.inc;

   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      dpc_bcd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .clr       (cmd.clr),
         .carry_in  (carry[i]),
         .carry_out (carry[i+1]),
         .digit     (rsp_count_digits[BCD_W*i +: BCD_W])
      );
   end

   // binary copy wraps with the digit row
   always_comb begin
      count_in = count_ff;
      if (cmd.clr) begin
         count_in = '0;
      end else if (cmd.inc) begin
         count_in = carry[DIGITS] ? '0 : count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_count_value = count_ff;
   assign rsp_event_code  = event_code;

   a_long_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_code == EV_LONG) |->
         (rsp_count_value == '0 && rsp_count_digits == '0))
      else $error("long press word does not show a cleared counter");

   a_short_counts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && cmd.inc) |=>
         (count_ff == $past(count_ff) + COUNT_W'(1) || count_ff == '0))
      else $error("short press did not advance the counter");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> ($stable(count_ff) && $stable(rsp_count_digits)))
      else $error("counter changed without an accepted tick");

   a_digits_agree: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (rsp_count_digits == '0))
      else $error("binary and decimal counts disagree at zero");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives button ticks into the debounced press counter at random rates,
// predicts each tick's count, digits and event code, and compares them with
// the result channel. Runs through several debounce and long-press settings.
// ----------------------------------------------------------------------------
module testbench;
   import dpc_pkg::*;

   localparam int DIGIT_W = BCD_W * 9;
   localparam logic [COUNT_W-1:0] COUNT_TOP = 30'd999_999_999;

   typedef struct packed {
      logic [COUNT_W-1:0] value;
      logic [DIGIT_W-1:0] digits;
      event_type          ev;
   } tick_result_type;

   // tracks the press counter state and the results still owed by the block
   class press_scoreboard;
      phase_type            phase;
      logic [15:0]          hold_timer;
      logic [COUNT_W-1:0]   count;
      logic [DIGIT_W-1:0]   digits;
      logic [DB_TICKS_W-1:0] debounce_limit;
      logic [LP_TICKS_W-1:0] long_limit;
      tick_result_type      owed_q[$];
      int                   mismatches;
      int                   checked;
      int                   shorts;
      int                   longs;

      function new();
         phase          = PH_IDLE;
         hold_timer     = '0;
         count          = '0;
         digits         = '0;
         debounce_limit = DB_TICKS_RESET;
         long_limit     = LP_TICKS_RESET;
         mismatches     = 0;
         checked        = 0;
         shorts         = 0;
         longs          = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_DEBOUNCE_TICKS)
            debounce_limit = data[DB_TICKS_W-1:0];
         else
            long_limit = data[LP_TICKS_W-1:0];
      endfunction

      function void note_tick(logic level);
         tick_result_type r;
         logic         pressed;
         logic         carry;
         r.ev = EV_NONE;
         pressed = (level == 1'b0);
         case (phase)
            PH_IDLE: begin
               if (pressed) begin
                  phase = PH_DEBOUNCE;
                  hold_timer = '0;
               end
            end
            PH_DEBOUNCE: begin
               if (hold_timer != '1) hold_timer++;
               if (hold_timer >= {8'd0, debounce_limit}) begin
                  if (pressed) begin
                     phase = PH_HOLD;
                     hold_timer = '0;
                  end else begin
                     phase = PH_IDLE;
                  end
               end
            end
            PH_HOLD: begin
               if (hold_timer != '1) hold_timer++;
               if (hold_timer >= long_limit) begin
                  count = '0;
                  digits = '0;
                  r.ev = EV_LONG;
                  longs++;
                  phase = pressed ? PH_WAIT_RELEASE : PH_IDLE;
               end else if (!pressed) begin
                  // binary and decimal copies advance independently
                  if (count >= COUNT_TOP)
                     count = '0;
                  else
                     count++;
                  carry = 1'b1;
                  for (int i = 0; i < 9; i++) begin
                     if (carry) begin
                        if (digits[4*i +: 4] < BCD_NINE) begin
                           digits[4*i +: 4] = digits[4*i +: 4] + 4'd1;
                           carry = 1'b0;
                        end else begin
                           digits[4*i +: 4] = 4'd0;
                        end
                     end
                  end
                  r.ev = EV_SHORT;
                  shorts++;
                  phase = PH_IDLE;
               end
            end
            default: begin
               if (!pressed) phase = PH_IDLE;
            end
         endcase
         r.value = count;
         r.digits = digits;
         owed_q.push_back(r);
      endfunction

      function void check_result(logic [COUNT_W-1:0] value, logic [DIGIT_W-1:0] dig,
                                 logic [1:0] ev);
         tick_result_type want;
         checked++;
         if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected word value=%0d digits=%h event=%0d",
                        $realtime, value, dig, ev);
            return;
         end
         want = owed_q.pop_front();
         if (value !== want.value || dig !== want.digits || ev !== want.ev) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch value %0d/%0d digits %h/%h event %0d/%0d (exp/got)",
                        $realtime, want.value, value, want.digits, dig, want.ev, ev);
         end
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_button_level = 1'b1;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [COUNT_W-1:0]      rsp_count_value;
   logic [DIGIT_W-1:0]      rsp_count_digits;
   logic [1:0]              rsp_event_code;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = CSR_DEBOUNCE_TICKS;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   press_scoreboard sb;
   int ticks_sent = 0;
   int burst_left = 0;
   int settings_used = 1;
   int cur_db = 2;
   int cur_lp = 200;
   int stall_left = 0;
   int stall_mode = 0;
   logic [2:0] stall_cnt = '0;

   debounced_press_counter_long_reset dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_button_level (req_button_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_count_value  (rsp_count_value),
      .rsp_count_digits (rsp_count_digits),
      .rsp_event_code   (rsp_event_code),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side: check accepted words, stall in changing patterns
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_count_value, rsp_count_digits, rsp_event_code);
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
         end else begin
            stall_left--;
         end
         stall_cnt <= stall_cnt + 3'd1;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= (stall_cnt < 3'd3);
         endcase
      end
   end

   task automatic send_tick(input logic level);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_button_level <= level;
      do @(posedge clock); while (req_stall);
      sb.note_tick(level);
      ticks_sent++;
   endtask

   // levels are sent msb first
   task automatic send_pattern(input logic [31:0] levels, input int n);
      for (int i = n - 1; i >= 0; i--)
         send_tick(levels[i]);
   endtask

   // held pressed ticks from the first press, then a short release
   task automatic press_seq(input int held, input bit noisy);
      logic lvl;
      for (int i = 0; i < held; i++) begin
         lvl = 1'b0;
         // samples inside the debounce wait are ignored, so bounce them
         if (noisy && i > 0 && i < cur_db) lvl = ($urandom_range(0, 1) == 1);
         send_tick(lvl);
      end
      repeat ($urandom_range(1, 3)) send_tick(1'b1);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_beat(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] db_data,
                             input logic [CSR_DATA_W-1:0] lp_data);
      wait_idle();
      csr_valid <= 1'b1;
      csr_beat(CSR_DEBOUNCE_TICKS, db_data);
      csr_beat(CSR_LONG_PRESS_TICKS, lp_data);
      csr_valid <= 1'b0;
      // a debounce of zero confirms on the next tick, same as one
      cur_db = (db_data[7:0] == 8'd0) ? 1 : int'(db_data[7:0]);
      cur_lp = int'(lp_data);
      settings_used++;
      @(posedge clock);
   endtask

   task automatic run_random(input int n);
      int stop_at;
      int pick;
      int lim;
      int j;
      stop_at = ticks_sent + n;
      while (ticks_sent < stop_at) begin
         pick = $urandom_range(0, 9);
         if (pick <= 4 && cur_lp >= 2) begin
            lim = (cur_lp - 1 < 10) ? cur_lp - 1 : 10;
            press_seq(cur_db + int'($urandom_range(1, lim)), $urandom_range(0, 1) == 1);
         end else if (pick <= 6 && cur_lp <= 300) begin
            // release just before, at or after the long-press limit
            j = cur_lp - 1 + int'($urandom_range(0, 4));
            if (j < 1) j = 1;
            press_seq(cur_db + j, $urandom_range(0, 1) == 1);
         end else if (pick == 7) begin
            press_seq($urandom_range(1, cur_db), 1'b1);
         end else begin
            repeat ($urandom_range(1, 6)) send_tick($urandom_range(0, 1) == 1);
         end
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] db_data;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: idle tick, bounce rejected, short press, glitch in debounce
      send_pattern(32'b1011000101001, 13);
      // debounce zero and long-press zero: clear then wait for release
      set_config(16'hA500, 16'h0000);
      send_pattern(32'b00001, 5);
      // long press released on the very tick it fires
      set_config(16'h0001, 16'h0001);
      send_pattern(32'b0011, 4);
      run_random(130);

      set_config({8'h00, DB_TICKS_RESET}, LP_TICKS_RESET);
      run_random(200);
      set_config(16'hFF00, 16'h0000);
      run_random(130);
      repeat (5) begin
         db_data = CSR_DATA_W'($urandom);
         db_data[7:0] = 8'($urandom_range(1, 8));
         set_config(db_data, CSR_DATA_W'($urandom_range(1, 40)));
         run_random(140);
      end
      set_config(16'h5AFF, 16'd20);
      run_random(150);
      // widest limit: a long hold still far below it only counts
      set_config(16'h0003, 16'hFFFF);
      press_seq(cur_db + 40, 1'b0);
      run_random(100);

      wait_idle();
      repeat (4) @(posedge clock);
      $display("ran %0d ticks over %0d settings, %0d words checked", ticks_sent,
               settings_used, sb.checked);
      $display("saw %0d counted presses and %0d long-press clears", sb.shorts, sb.longs);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("testbench OK");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("timeout");
      $display("testbench NOT OK");
      $finish;
   end

endmodule
